// ===== design/stream_byte_reassembler_defines.svh =====
// Assertion macros shared by the stream byte reassembler.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef STREAM_BYTE_REASSEMBLER_DEFINES_SVH
`define STREAM_BYTE_REASSEMBLER_DEFINES_SVH

// Same-cycle implication, checked only out of reset.
`define SBR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stream_byte_reassembler: same-cycle check failed");

// Next-cycle implication, checked only out of reset.
`define SBR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stream_byte_reassembler: next-cycle check failed");

`endif

// ===== design/sbr_pkg.sv =====
// Types and constants shared by the stream byte reassembler modules.
// No dependencies.
package sbr_pkg;

    localparam int IDX_W  = 64;
    localparam int BYTE_W = 8;
    localparam int ROOM_W = 7;
    localparam int PEND_W = 7;

    // Command queue between front and back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    // One classified item, handed from the front to the back.
    typedef struct packed {
        logic              store;
        logic [BYTE_W-1:0] data;
        logic [ROOM_W-1:0] offset;
        logic              end_set;
        logic [IDX_W-1:0]  end_pos;
    } sbr_cmd_t;

    // Stream position state that the front needs to classify an item.
    typedef struct packed {
        logic [IDX_W-1:0] next_expected;
        logic             end_known;
        logic [IDX_W-1:0] end_pos;
    } sbr_state_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CHECK,
        BK_EMIT
    } back_state_t;

endpackage

// ===== design/stream_byte_reassembler.sv =====
// Path: front register, command queue, BK_CHECK (status-only beat, or read of the first byte),
// then BK_EMIT. Bytes drain one per cycle through the window memory read port; busy stays high,
// so no new item is taken, until the last beat is out.
// Reset: asynchronous, active low; clears the valid bitmap, stream position and end state.
// The window memory is not cleared; only valid slots are ever read.
// Results cannot be stalled by the receiver.
`include "stream_byte_reassembler_defines.svh"

module stream_byte_reassembler #(
    parameter int WINDOW = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [sbr_pkg::IDX_W-1:0]  stream_index,
    input  logic [sbr_pkg::BYTE_W-1:0] data_byte,
    input  logic                       has_byte,
    input  logic                       ends_stream,
    input  logic [sbr_pkg::ROOM_W-1:0] room,
    output logic                       result_strobe,
    output logic [sbr_pkg::BYTE_W-1:0] out_byte,
    output logic                       out_valid,
    output logic                       stream_closed,
    output logic [sbr_pkg::PEND_W-1:0] pending_count,
    output logic                       last_of_run
);
    import sbr_pkg::*;

    logic       take;
    logic       holding;
    logic       push;
    logic       pop;
    logic       q_valid;
    logic       q_full;
    logic       bk_busy;
    sbr_cmd_t   front_cmd;
    sbr_cmd_t   head_cmd;
    sbr_state_t bk_state;

    assign busy = holding || q_valid || bk_busy;
    assign take = start && !busy;

    sbr_front #(
        .WINDOW(WINDOW)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .stream_index (stream_index),
        .data_byte    (data_byte),
        .has_byte     (has_byte),
        .ends_stream  (ends_stream),
        .room         (room),
        .bk_state     (bk_state),
        .q_full       (q_full),
        .holding      (holding),
        .push         (push),
        .cmd          (front_cmd)
    );

    sbr_cmdq u_cmdq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (front_cmd),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_full   (q_full),
        .head     (head_cmd)
    );

    sbr_back #(
        .WINDOW(WINDOW)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .cmd           (head_cmd),
        .pop           (pop),
        .bk_state      (bk_state),
        .bk_busy       (bk_busy),
        .result_strobe (result_strobe),
        .out_byte      (out_byte),
        .out_valid     (out_valid),
        .stream_closed (stream_closed),
        .pending_count (pending_count),
        .last_of_run   (last_of_run)
    );

    // An accepted item keeps the block busy until its last beat is out.
    `SBR_ASSERT_NEXT(a_busy_after_take, take, busy)
    `SBR_ASSERT_NEXT(a_idle_after_last, result_strobe && last_of_run, !busy)
    // A beat with no byte is always the lone status beat of its item.
    `SBR_ASSERT_NOW(a_status_beat, result_strobe && !out_valid, last_of_run && (out_byte == '0))
    `SBR_ASSERT_NOW(a_pending_bound, result_strobe, pending_count <= PEND_W'(WINDOW))

endmodule

// ===== design/sbr_front.sv =====
// Front end: registers an accepted item and classifies it against the stream state.
// Depends on sbr_pkg.
module sbr_front #(
    parameter int WINDOW = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       take,
    input  logic [sbr_pkg::IDX_W-1:0]  stream_index,
    input  logic [sbr_pkg::BYTE_W-1:0] data_byte,
    input  logic                       has_byte,
    input  logic                       ends_stream,
    input  logic [sbr_pkg::ROOM_W-1:0] room,
    input  sbr_pkg::sbr_state_t        bk_state,
    input  logic                       q_full,
    output logic                       holding,
    output logic                       push,
    output sbr_pkg::sbr_cmd_t          cmd
);
    import sbr_pkg::*;

    logic              valid_reg, valid_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [BYTE_W-1:0] data_reg;
    logic              has_reg;
    logic              ends_reg;
    logic [ROOM_W-1:0] room_reg;

    logic [ROOM_W-1:0] room_c;
    logic [IDX_W-1:0]  diff;
    logic              ahead;
    logic              in_room;
    logic              past_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            idx_reg  <= stream_index;
            data_reg <= data_byte;
            has_reg  <= has_byte;
            ends_reg <= ends_stream;
            room_reg <= room;
        end
    end

    always_comb
    begin
        room_c  = (room_reg > ROOM_W'(WINDOW)) ? ROOM_W'(WINDOW) : room_reg;
        diff    = idx_reg - bk_state.next_expected;
        ahead   = (idx_reg >= bk_state.next_expected);
        in_room = (diff[IDX_W-1:ROOM_W] == '0) && (diff[ROOM_W-1:0] < room_c);

        // A byte that ends the stream sits below its own end index, unless
        // that index wrapped past the top of the index space.
        if (ends_reg)
        begin
            past_end = has_reg && (idx_reg == '1);
        end
        else
        begin
            past_end = bk_state.end_known && (idx_reg >= bk_state.end_pos);
        end

        cmd.store   = has_reg && ahead && in_room && !past_end;
        cmd.data    = data_reg;
        cmd.offset  = diff[ROOM_W-1:0];
        cmd.end_set = ends_reg;
        cmd.end_pos = has_reg ? (idx_reg + IDX_W'(1)) : idx_reg;

        push       = valid_reg && !q_full;
        valid_next = take || (valid_reg && !push);
        holding    = valid_reg;
    end

endmodule

// ===== design/sbr_cmdq.sv =====
// Short command queue between the front and the back.
// Depends on sbr_pkg.
module sbr_cmdq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sbr_pkg::sbr_cmd_t push_cmd,
    input  logic              pop,
    output logic              q_valid,
    output logic              q_full,
    output sbr_pkg::sbr_cmd_t head
);
    import sbr_pkg::*;

    sbr_cmd_t          entries [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    always_comb
    begin
        q_valid     = (count_reg != '0);
        q_full      = (count_reg == QCNT_W'(QDEPTH));
        do_push     = push && !q_full;
        do_pop      = pop && q_valid;
        head        = entries[rd_ptr_reg];
        wr_ptr_next = do_push ? (wr_ptr_reg + QPTR_W'(1)) : wr_ptr_reg;
        rd_ptr_next = do_pop ? (rd_ptr_reg + QPTR_W'(1)) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== design/sbr_back.sv =====
// Back end: window memory, valid bitmap, stream position and the in-order drain.
// Depends on sbr_pkg.
module sbr_back #(
    parameter int WINDOW = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  sbr_pkg::sbr_cmd_t          cmd,
    output logic                       pop,
    output sbr_pkg::sbr_state_t        bk_state,
    output logic                       bk_busy,
    output logic                       result_strobe,
    output logic [sbr_pkg::BYTE_W-1:0] out_byte,
    output logic                       out_valid,
    output logic                       stream_closed,
    output logic [sbr_pkg::PEND_W-1:0] pending_count,
    output logic                       last_of_run
);
    import sbr_pkg::*;

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W  = 8;
    localparam int CNT_W  = $clog2(WINDOW + 1);

    back_state_t       state_reg, state_next;
    logic [IDX_W-1:0]  ne_reg, ne_next;
    logic [SLOT_W-1:0] ne_slot_reg, ne_slot_next;
    logic [PEND_W-1:0] held_reg, held_next;
    logic              end_known_reg, end_known_next;
    logic [IDX_W-1:0]  end_pos_reg, end_pos_next;
    logic              closed_reg, closed_next;
    logic [WINDOW-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]  run_cnt_reg, run_cnt_next;

    logic [BYTE_W-1:0] mem [WINDOW];
    logic [BYTE_W-1:0] rdata_reg;

    logic [SUM_W-1:0]  slot_sum;
    logic [SLOT_W-1:0] slot_w;
    logic              wr_en;
    logic              issue;
    logic              can_drain;

    always_comb
    begin
        state_next     = state_reg;
        ne_next        = ne_reg;
        ne_slot_next   = ne_slot_reg;
        held_next      = held_reg;
        end_known_next = end_known_reg;
        end_pos_next   = end_pos_reg;
        closed_next    = closed_reg;
        valid_next     = valid_reg;
        run_cnt_next   = run_cnt_reg;
        pop            = 1'b0;
        wr_en          = 1'b0;
        issue          = 1'b0;
        result_strobe  = 1'b0;
        out_byte       = '0;
        out_valid      = 1'b0;
        last_of_run    = 1'b0;

        // The offset is below the window size, so one subtract wraps the slot.
        slot_sum = SUM_W'(ne_slot_reg) + SUM_W'(cmd.offset);
        if (slot_sum >= SUM_W'(WINDOW))
        begin
            slot_w = SLOT_W'(slot_sum - SUM_W'(WINDOW));
        end
        else
        begin
            slot_w = SLOT_W'(slot_sum);
        end

        can_drain = !closed_reg && valid_reg[ne_slot_reg] && (run_cnt_reg < CNT_W'(WINDOW));

        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    pop = 1'b1;
                    if (!closed_reg)
                    begin
                        end_known_next = end_known_reg || cmd.end_set;
                        end_pos_next   = cmd.end_set ? cmd.end_pos : end_pos_reg;
                        if (cmd.store && !valid_reg[slot_w])
                        begin
                            wr_en              = 1'b1;
                            valid_next[slot_w] = 1'b1;
                            held_next          = held_reg + PEND_W'(1);
                        end
                        if (end_known_next && (ne_reg == end_pos_next))
                        begin
                            closed_next = 1'b1;
                        end
                    end
                    run_cnt_next = '0;
                    state_next   = BK_CHECK;
                end
            end
            BK_CHECK:
            begin
                if (can_drain)
                begin
                    issue      = 1'b1;
                    state_next = BK_EMIT;
                end
                else
                begin
                    // Nothing to write: a single status beat.
                    result_strobe = 1'b1;
                    last_of_run   = 1'b1;
                    state_next    = BK_IDLE;
                end
            end
            BK_EMIT:
            begin
                result_strobe = 1'b1;
                out_byte      = rdata_reg;
                out_valid     = 1'b1;
                last_of_run   = !can_drain;
                if (can_drain)
                begin
                    issue = 1'b1;
                end
                else
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        if (issue)
        begin
            valid_next[ne_slot_reg] = 1'b0;
            if (held_reg != '0)
            begin
                held_next = held_reg - PEND_W'(1);
            end
            ne_next = ne_reg + IDX_W'(1);
            if (ne_slot_reg == SLOT_W'(WINDOW - 1))
            begin
                ne_slot_next = '0;
            end
            else
            begin
                ne_slot_next = ne_slot_reg + SLOT_W'(1);
            end
            closed_next  = end_known_reg && (ne_next == end_pos_reg);
            run_cnt_next = run_cnt_reg + CNT_W'(1);
        end

        stream_closed          = closed_reg;
        pending_count          = held_reg;
        bk_busy                = (state_reg != BK_IDLE);
        bk_state.next_expected = ne_reg;
        bk_state.end_known     = end_known_reg;
        bk_state.end_pos       = end_pos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            ne_reg        <= '0;
            ne_slot_reg   <= '0;
            held_reg      <= '0;
            end_known_reg <= 1'b0;
            end_pos_reg   <= '0;
            closed_reg    <= 1'b0;
            valid_reg     <= '0;
            run_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ne_reg        <= ne_next;
            ne_slot_reg   <= ne_slot_next;
            held_reg      <= held_next;
            end_known_reg <= end_known_next;
            end_pos_reg   <= end_pos_next;
            closed_reg    <= closed_next;
            valid_reg     <= valid_next;
            run_cnt_reg   <= run_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[slot_w] <= cmd.data;
        end
        if (issue)
        begin
            rdata_reg <= mem[ne_slot_reg];
        end
    end

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for stream_byte_reassembler: bytes tagged with stream indexes are
// sent out of order, and every written beat is checked against a predictor kept here.
// Depends on sbr_pkg and the stream_byte_reassembler RTL.
module tb;

    localparam int WINDOW_SLOTS = 64;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [sbr_pkg::IDX_W-1:0]  idx;
        logic [sbr_pkg::BYTE_W-1:0] data;
        bit                         has;
        bit                         ends;
        logic [sbr_pkg::ROOM_W-1:0] room;
    } stream_beat_t;

    typedef struct {
        logic [sbr_pkg::BYTE_W-1:0] data;
        bit                         valid;
        bit                         closed;
        logic [sbr_pkg::PEND_W-1:0] pending;
        bit                         last;
    } written_beat_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [sbr_pkg::IDX_W-1:0]  stream_index = '0;
    logic [sbr_pkg::BYTE_W-1:0] data_byte = '0;
    logic                       has_byte = 1'b0;
    logic                       ends_stream = 1'b0;
    logic [sbr_pkg::ROOM_W-1:0] room = '0;
    logic                       result_strobe;
    logic [sbr_pkg::BYTE_W-1:0] out_byte;
    logic                       out_valid;
    logic                       stream_closed;
    logic [sbr_pkg::PEND_W-1:0] pending_count;
    logic                       last_of_run;

    stream_byte_reassembler #(.WINDOW(WINDOW_SLOTS)) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .stream_index(stream_index),
        .data_byte(data_byte),
        .has_byte(has_byte),
        .ends_stream(ends_stream),
        .room(room),
        .result_strobe(result_strobe),
        .out_byte(out_byte),
        .out_valid(out_valid),
        .stream_closed(stream_closed),
        .pending_count(pending_count),
        .last_of_run(last_of_run)
    );

    always #5 clk = ~clk;

    stream_beat_t  beats_to_send[$];
    written_beat_t expected_writes[$];
    int            mismatches = 0;

    // Predictor state: the ring window and the stream position.
    logic [7:0]    slot_data[WINDOW_SLOTS];
    bit            slot_held[WINDOW_SLOTS];
    logic [63:0]   next_idx = '0;
    int unsigned   held_bytes = 0;
    bit            end_seen = 1'b0;
    logic [63:0]   end_idx = '0;
    bit            stream_done = 1'b0;

    // Index of the next byte the stimulus plans to send in order.
    logic [63:0]   plan_base = '0;

    // Store the byte if it fits, then drain the contiguous run from the next index.
    function automatic void reassemble_beat(stream_beat_t it);
        int unsigned   lim;
        int            slot;
        int            k;
        bit            have_prev;
        written_beat_t prev;
        written_beat_t r;
        k = 0;
        have_prev = 1'b0;
        if (!stream_done) begin
            if (it.ends) begin
                end_seen = 1'b1;
                end_idx = it.has ? it.idx + 64'd1 : it.idx;
            end
            lim = (it.room > WINDOW_SLOTS) ? WINDOW_SLOTS : it.room;
            if (it.has && it.idx >= next_idx && (it.idx - next_idx) < lim
                    && !(end_seen && it.idx >= end_idx)) begin
                slot = int'(it.idx % WINDOW_SLOTS);
                if (!slot_held[slot]) begin
                    slot_data[slot] = it.data;
                    slot_held[slot] = 1'b1;
                    held_bytes++;
                end
            end
            if (end_seen && next_idx == end_idx)
                stream_done = 1'b1;
            while (!stream_done && k < WINDOW_SLOTS && slot_held[int'(next_idx % WINDOW_SLOTS)])
            begin
                slot = int'(next_idx % WINDOW_SLOTS);
                r.data = slot_data[slot];
                slot_held[slot] = 1'b0;
                if (held_bytes > 0)
                    held_bytes--;
                next_idx++;
                if (end_seen && next_idx == end_idx)
                    stream_done = 1'b1;
                r.valid = 1'b1;
                r.closed = stream_done;
                r.pending = held_bytes[6:0];
                r.last = 1'b0;
                if (have_prev)
                    expected_writes = {expected_writes, prev};
                prev = r;
                have_prev = 1'b1;
                k++;
            end
        end
        if (!have_prev) begin
            prev.data = '0;
            prev.valid = 1'b0;
            prev.closed = stream_done;
            prev.pending = held_bytes[6:0];
        end
        prev.last = 1'b1;
        expected_writes = {expected_writes, prev};
    endfunction

    int calm_left = 0;

    // Mostly short gaps, a few long ones, and now and then a stretch with none.
    function automatic int pick_gap();
        int roll;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
            calm_left = $urandom_range(10, 30);
        roll = $urandom_range(0, 19);
        if (roll < 10)
            return 0;
        if (roll < 18)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic queue_beat(logic [63:0] idx, logic [7:0] data, bit has, bit ends,
                              logic [6:0] rm);
        stream_beat_t b;
        b.idx = idx;
        b.data = data;
        b.has = has;
        b.ends = ends;
        b.room = rm;
        beats_to_send = {beats_to_send, b};
    endtask

    // A beat that changes nothing stored: stale, out of room, far away, or an empty marker.
    task automatic queue_noise(logic [63:0] lo, logic [63:0] hi, bit allow_end);
        int          kind;
        int          r;
        logic [63:0] far;
        kind = $urandom_range(0, 4);
        far = {$urandom, $urandom};
        far[63] = 1'b1;
        far[0] = 1'b0;
        case (kind)
            0: queue_beat(lo - 64'd1
                          - 64'($urandom_range(0, (lo > 64'd200) ? 199 : int'(lo) - 1)),
                          8'($urandom), 1'b1, 1'b0, 7'($urandom_range(0, WINDOW_SLOTS)));
            1:
            begin
                r = $urandom_range(0, 100);
                queue_beat(hi + 64'(r), 8'($urandom), 1'b1, 1'b0,
                           7'($urandom_range(0, (r > WINDOW_SLOTS) ? WINDOW_SLOTS : r)));
            end
            2: queue_beat(far, 8'($urandom), 1'b1, allow_end && ($urandom_range(0, 1) != 0),
                          7'($urandom_range(0, WINDOW_SLOTS)));
            3: queue_beat({$urandom, $urandom}, 8'($urandom), 1'b0, 1'b0,
                          7'($urandom_range(0, WINDOW_SLOTS)));
            default: queue_beat(far, 8'($urandom), 1'b0, allow_end,
                                7'($urandom_range(0, WINDOW_SLOTS)));
        endcase
    endtask

    // Every byte from plan_base to plan_base+len-1 in shuffled order, with duplicates and
    // noise mixed in. Each byte gets enough room to be stored, so the run always completes.
    task automatic queue_chunk(int len, bit hold_head, bit closing);
        int order[$];
        int i;
        int j;
        int t;
        for (i = 0; i < len; i++)
            order = {order, i};
        for (i = len - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        if (hold_head)
        begin
            for (i = 0; i < len; i++)
                if (order[i] == 0)
                begin
                    order[i] = order[len - 1];
                    order[len - 1] = 0;
                end
        end
        for (i = 0; i < len; i++)
        begin
            queue_beat(plan_base + 64'(order[i]), 8'($urandom), 1'b1,
                       closing && order[i] == len - 1,
                       7'($urandom_range(order[i] + 1, WINDOW_SLOTS)));
            if ($urandom_range(0, 4) == 0)
                queue_noise(plan_base, plan_base + 64'(len), !closing);
            if ($urandom_range(0, 7) == 0)
                queue_beat(plan_base + 64'(order[$urandom_range(0, i)]), 8'($urandom),
                           1'b1, 1'b0, 7'($urandom_range(0, WINDOW_SLOTS)));
        end
        plan_base += 64'(len);
    endtask

    initial
    begin
        int len;
        bit first;
        first = 1'b1;
        // Directed part, starting from the reset position.
        queue_beat(64'd0, 8'h00, 1'b0, 1'b0, 7'd64);     // nothing to write
        queue_beat(64'd1, 8'hff, 1'b1, 1'b0, 7'd64);     // held, not contiguous
        queue_beat(64'd0, 8'h00, 1'b1, 1'b0, 7'd1);      // releases bytes 0 and 1
        queue_beat(64'd0, 8'hff, 1'b1, 1'b0, 7'd64);     // already written
        queue_beat(64'd7, 8'h5a, 1'b1, 1'b0, 7'd5);      // just past the room
        queue_beat(64'd3, 8'h11, 1'b1, 1'b0, 7'd0);      // no room at all
        queue_beat(64'd3, 8'haa, 1'b1, 1'b0, 7'd64);
        queue_beat(64'd3, 8'h55, 1'b1, 1'b0, 7'd64);     // duplicate keeps the first value
        queue_beat(64'd2, 8'hff, 1'b1, 1'b0, 7'd1);
        // A dropped final byte at the top index still records its end, which wraps to zero.
        queue_beat(64'hffff_ffff_ffff_ffff, 8'h80, 1'b1, 1'b1, 7'd64);
        queue_beat(64'd4, 8'h01, 1'b1, 1'b0, 7'd64);     // at or past the known end
        queue_beat(64'h8000_0000_0000_0000, 8'h00, 1'b0, 1'b1, 7'd64);  // newer end wins
        queue_beat(64'd4, 8'h7e, 1'b1, 1'b0, 7'd64);
        plan_base = 64'd5;

        while (beats_to_send.size() < 295)
        begin
            if (first)
                len = WINDOW_SLOTS;
            else if ($urandom_range(0, 7) == 0)
                len = $urandom_range(40, WINDOW_SLOTS);
            else
                len = $urandom_range(1, 12);
            queue_chunk(len, first || $urandom_range(0, 3) == 0, 1'b0);
            first = 1'b0;
        end
        queue_chunk($urandom_range(1, 8), 1'b0, 1'b1);

        // The stream is closed now; everything below is ignored.
        queue_beat(plan_base, 8'($urandom), 1'b1, 1'b0, 7'd64);
        queue_beat(plan_base + 64'd10, 8'($urandom), 1'b0, 1'b1, 7'd64);
        queue_beat(plan_base + 64'd1, 8'($urandom), 1'b1, 1'b1, 7'd32);
        queue_beat(64'd0, 8'($urandom), 1'b0, 1'b0, 7'd0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (beats_to_send.size() != 0 || start || expected_writes.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0 && expected_writes.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    stream_beat_t driven_item;
    int           gap_left = 0;
    bit           accepted;

    // Driver: a beat is taken at an edge where start is high and busy is low.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            accepted = start && !busy;
            if (accepted)
            begin
                reassemble_beat(driven_item);
                gap_left = pick_gap();
            end
            if (accepted || !start)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (beats_to_send.size() > 0)
                begin
                    driven_item = beats_to_send.pop_front();
                    stream_index <= driven_item.idx;
                    data_byte <= driven_item.data;
                    has_byte <= driven_item.has;
                    ends_stream <= driven_item.ends;
                    room <= driven_item.room;
                    start <= 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    written_beat_t want;

    // Monitor: each strobed result is compared with the oldest expected write.
    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
        begin
            if (expected_writes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: byte %h valid %b closed %b pending %0d last %b",
                             out_byte, out_valid, stream_closed, pending_count, last_of_run);
            end
            else
            begin
                want = expected_writes.pop_front();
                if (out_byte !== want.data || out_valid !== want.valid
                        || stream_closed !== want.closed || pending_count !== want.pending
                        || last_of_run !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: got byte %h valid %b closed %b pending %0d last %b, %s",
                                 out_byte, out_valid, stream_closed, pending_count, last_of_run,
                                 $sformatf("want byte %h valid %b closed %b pending %0d last %b",
                                           want.data, want.valid, want.closed, want.pending,
                                           want.last));
                end
            end
        end
    end

    initial
    begin
        #3000000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== stream_byte_reassembler.f =====
+incdir+design
design/sbr_pkg.sv
design/sbr_front.sv
design/sbr_cmdq.sv
design/sbr_back.sv
design/stream_byte_reassembler.sv
test/tb.sv
